// ----- rtl/core/smm_pkg.sv -----
// shared constants and types for the square matrix multiplier
package smm_pkg;

  // matrix geometry
  localparam int MAX_SIZE     = 8;
  localparam int ELEMENT_BITS = 16;
  localparam int STORE_DEPTH  = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_BITS    = $clog2(STORE_DEPTH);
  localparam int IDX_BITS     = 3;
  localparam int SIZE_BITS    = 4;
  localparam int COUNT_BITS   = ADDR_BITS + 1;
  localparam int MUL_BITS     = 2 * ELEMENT_BITS;
  localparam int PRODUCT_BITS = 36;
  localparam int OP_BITS      = 2;

  // configuration port
  localparam int APB_ADDR_BITS = 2;
  localparam int APB_DATA_BITS = 32;
  localparam logic [APB_ADDR_BITS-1:0] MATRIX_SIZE_ADDR  = 2'd0;
  localparam logic [SIZE_BITS-1:0]     MATRIX_SIZE_RESET = 4'd8;

  // command codes
  typedef enum logic [OP_BITS-1:0] {
    OP_LOAD_LEFT  = 2'd0,
    OP_LOAD_RIGHT = 2'd1,
    OP_COMPUTE    = 2'd2
  } op_t;

endpackage

// ----- rtl/core/smm_ram.sv -----
// generic single-write, single-read synchronous ram with registered read
module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/square_matrix_multiply.sv -----
// square signed matrix multiplier: top level with loader, sequencer and mac pipeline
// load beats may follow back to back; busy stays low
// a compute beat with size n holds busy until the final product entry is emitted (n = 0: busy stays low)
// one multiply-accumulate per cycle on a single 16x16 multiplier fed by two ram read ports
// product entries appear in row-major order after the compute beat
// reset clears both write counters, the ram valid bits (stores read zero) and sets size to 8
module square_matrix_multiply (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  logic [smm_pkg::OP_BITS-1:0]              op,
  input  logic signed [smm_pkg::ELEMENT_BITS-1:0]  element_value,
  output logic                                     result_valid,
  output logic signed [smm_pkg::PRODUCT_BITS-1:0]  product_value,
  output logic [smm_pkg::IDX_BITS-1:0]             result_row,
  output logic [smm_pkg::IDX_BITS-1:0]             result_col,
  output logic                                     last_entry,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [smm_pkg::APB_ADDR_BITS-1:0]        paddr,
  input  logic [smm_pkg::APB_DATA_BITS-1:0]        pwdata,
  output logic [smm_pkg::APB_DATA_BITS-1:0]        prdata,
  output logic                                     pready
);

  import smm_pkg::*;

  typedef struct packed {
    logic                first;
    logic                last_k;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
    logic                last;
  } mac_tag_t;

  logic [SIZE_BITS-1:0]    matrix_size;
  logic                    cfg_write;
  logic [SIZE_BITS-1:0]    n_use;
  logic [2*SIZE_BITS-1:0]  total_full;
  logic [COUNT_BITS-1:0]   total;
  logic                    accept;
  op_t                     cmd;

  logic [COUNT_BITS-1:0]   left_count;
  logic [COUNT_BITS-1:0]   right_count;
  logic [COUNT_BITS-1:0]   left_count_next;
  logic [COUNT_BITS-1:0]   right_count_next;
  logic                    left_we;
  logic                    right_we;
  logic                    run_start;
  logic [STORE_DEPTH-1:0]  left_valid;
  logic [STORE_DEPTH-1:0]  right_valid;

  logic                    run;
  logic [IDX_BITS-1:0]     row;
  logic [IDX_BITS-1:0]     col;
  logic [IDX_BITS-1:0]     k;
  logic [SIZE_BITS-1:0]    n_run;
  logic [IDX_BITS-1:0]     last_idx;
  logic [IDX_BITS+SIZE_BITS-1:0] row_base;
  logic [IDX_BITS+SIZE_BITS-1:0] k_base;
  logic [ADDR_BITS-1:0]    left_raddr;
  logic [ADDR_BITS-1:0]    right_raddr;
  mac_tag_t                issue_tag;

  logic [ELEMENT_BITS-1:0] left_rdata;
  logic [ELEMENT_BITS-1:0] right_rdata;
  logic                    s1_valid;
  mac_tag_t                s1_tag;
  logic                    s1_left_ok;
  logic                    s1_right_ok;
  logic signed [ELEMENT_BITS-1:0] mul_a;
  logic signed [ELEMENT_BITS-1:0] mul_b;

  logic                    s2_valid;
  mac_tag_t                s2_tag;
  logic signed [MUL_BITS-1:0]     prod;
  logic signed [PRODUCT_BITS-1:0] acc;
  logic signed [PRODUCT_BITS-1:0] acc_base;
  logic signed [PRODUCT_BITS-1:0] acc_sum;

  // configuration register
  assign cfg_write = psel & penable & pwrite & pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr == MATRIX_SIZE_ADDR) ? APB_DATA_BITS'(matrix_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= MATRIX_SIZE_RESET;
    end else if (cfg_write && paddr == MATRIX_SIZE_ADDR) begin
      matrix_size <= pwdata[SIZE_BITS-1:0];
    end
  end

  // size in use, saturated to the store dimension
  assign n_use      = (matrix_size > SIZE_BITS'(MAX_SIZE)) ? SIZE_BITS'(MAX_SIZE) : matrix_size;
  assign total_full = n_use * n_use;
  assign total      = total_full[COUNT_BITS-1:0];

  assign accept = start & ~busy;
  assign cmd    = op_t'(op);

  // command decode: element loads and compute launch
  always_comb begin
    left_we          = 1'b0;
    right_we         = 1'b0;
    left_count_next  = left_count;
    right_count_next = right_count;
    run_start        = 1'b0;
    if (accept) begin
      case (cmd)
        OP_LOAD_LEFT: begin
          if (left_count < total) begin
            left_we         = 1'b1;
            left_count_next = left_count + COUNT_BITS'(1);
          end else if (left_count > total) begin
            left_count_next = total;
          end
        end
        OP_LOAD_RIGHT: begin
          if (right_count < total) begin
            right_we         = 1'b1;
            right_count_next = right_count + COUNT_BITS'(1);
          end else if (right_count > total) begin
            right_count_next = total;
          end
        end
        OP_COMPUTE: begin
          left_count_next  = '0;
          right_count_next = '0;
          run_start        = (n_use != '0);
        end
        default: ;
      endcase
    end
  end

  // write counters and per-entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= '0;
      right_count <= '0;
      left_valid  <= '0;
      right_valid <= '0;
    end else begin
      left_count  <= left_count_next;
      right_count <= right_count_next;
      if (left_we) begin
        left_valid[left_count[ADDR_BITS-1:0]] <= 1'b1;
      end
      if (right_we) begin
        right_valid[right_count[ADDR_BITS-1:0]] <= 1'b1;
      end
    end
  end

  // element stores
  smm_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(STORE_DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (left_we),
    .waddr (left_count[ADDR_BITS-1:0]),
    .wdata (element_value),
    .raddr (left_raddr),
    .rdata (left_rdata)
  );

  smm_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(STORE_DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (right_we),
    .waddr (right_count[ADDR_BITS-1:0]),
    .wdata (element_value),
    .raddr (right_raddr),
    .rdata (right_rdata)
  );

  // read addresses: left (row, k), right (k, col)
  assign row_base    = row * n_run;
  assign k_base      = k * n_run;
  assign left_raddr  = ADDR_BITS'(row_base + k);
  assign right_raddr = ADDR_BITS'(k_base + col);

  always_comb begin
    issue_tag.first  = (k == '0);
    issue_tag.last_k = (k == last_idx);
    issue_tag.row    = row;
    issue_tag.col    = col;
    issue_tag.last   = (row == last_idx) && (col == last_idx);
  end

  // row, column and inner index sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (run_start) begin
      run      <= 1'b1;
      row      <= '0;
      col      <= '0;
      k        <= '0;
      n_run    <= n_use;
      last_idx <= IDX_BITS'(n_use - SIZE_BITS'(1));
    end else if (run) begin
      if (k == last_idx) begin
        k <= '0;
        if (col == last_idx) begin
          col <= '0;
          if (row == last_idx) begin
            run <= 1'b0;
          end else begin
            row <= row + IDX_BITS'(1);
          end
        end else begin
          col <= col + IDX_BITS'(1);
        end
      end else begin
        k <= k + IDX_BITS'(1);
      end
    end
  end

  // stage 1: ram data returns, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= run;
    end
    s1_tag      <= issue_tag;
    s1_left_ok  <= left_valid[left_raddr];
    s1_right_ok <= right_valid[right_raddr];
  end

  assign mul_a = s1_left_ok  ? left_rdata  : '0;
  assign mul_b = s1_right_ok ? right_rdata : '0;

  // stage 2: registered product
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_tag <= s1_tag;
    prod   <= mul_a * mul_b;
  end

  // stage 3: accumulate and emit on the last inner step
  assign acc_base = s2_tag.first ? '0 : acc;
  assign acc_sum  = acc_base + PRODUCT_BITS'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      busy         <= 1'b0;
    end else begin
      result_valid <= s2_valid & s2_tag.last_k;
      if (run_start) begin
        busy <= 1'b1;
      end else if (s2_valid && s2_tag.last_k && s2_tag.last) begin
        busy <= 1'b0;
      end
    end
    if (s2_valid) begin
      acc <= acc_sum;
    end
    if (s2_valid && s2_tag.last_k) begin
      product_value <= acc_sum;
      result_row    <= s2_tag.row;
      result_col    <= s2_tag.col;
      last_entry    <= s2_tag.last;
    end
  end

endmodule

// ----- rtl/core/smm_checker.sv -----
// port-level checker for the square matrix multiplier, bound to the top level
module smm_checker (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     busy,
  input logic                                     result_valid,
  input logic [smm_pkg::IDX_BITS-1:0]             result_row,
  input logic [smm_pkg::IDX_BITS-1:0]             result_col,
  input logic                                     last_entry
);

  // every beat but the final one of a product arrives while busy
  a_mid_beat_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_entry |-> busy)
    else $error("product beat outside a busy period");

  // busy ends exactly with the final beat of the product
  a_busy_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> result_valid && last_entry)
    else $error("busy dropped without the final product beat");

  // the final beat closes the stream
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_entry |=> !result_valid)
    else $error("product beat right after the final beat");

  // the final entry sits on the diagonal corner
  a_last_on_diag: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_entry |-> result_row == result_col)
    else $error("final beat not at the bottom right entry");

endmodule

bind square_matrix_multiply smm_checker u_smm_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .result_row   (result_row),
  .result_col   (result_col),
  .last_entry   (last_entry)
);
